// File: hdl/eight_way_motion_quantizer_defines.svh
`ifndef EIGHT_WAY_MOTION_QUANTIZER_DEFINES_SVH
`define EIGHT_WAY_MOTION_QUANTIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define EWMQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define EWMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ewmq_pkg.sv
`timescale 1ns / 1ps

package ewmq_pkg;

    typedef enum logic [1:0] {
        FUNC_MOTION = 2'd0,
        FUNC_CLICK  = 2'd1,
        FUNC_STEP   = 2'd2,
        FUNC_RESET  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        DIR_IDLE       = 4'd0,
        DIR_UP         = 4'd1,
        DIR_UP_RIGHT   = 4'd2,
        DIR_RIGHT      = 4'd3,
        DIR_DOWN_RIGHT = 4'd4,
        DIR_DOWN       = 4'd5,
        DIR_DOWN_LEFT  = 4'd6,
        DIR_LEFT       = 4'd7,
        DIR_UP_LEFT    = 4'd8,
        DIR_CLICK      = 4'd9
    } dir_t;

    localparam logic REG_PERIOD_MS = 1'b0;
    localparam logic REG_DEADZONE  = 1'b1;

    localparam logic [15:0] PERIOD_RESET   = 16'd100;
    localparam logic [15:0] PERIOD_MIN     = 16'd16;
    localparam logic [15:0] DEADZONE_RESET = 16'd32;

    typedef struct packed {
        func_t              func;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic fired;
        logic changed;
        dir_t direction;
    } result_t;

    typedef struct packed {
        logic [15:0] period_ms;
        logic [15:0] deadzone;
    } cfg_t;

endpackage

// File: hdl/ewmq_sector.sv
`timescale 1ns / 1ps

module ewmq_sector
    import ewmq_pkg::*;
#(
    parameter int ACCUM_BITS = 24
)
(
    input  logic signed [ACCUM_BITS-1:0] x,
    input  logic signed [ACCUM_BITS-1:0] y,
    input  logic [15:0]                  deadzone,
    output dir_t                         direction
);

    localparam int PROD_BITS = 2 * ACCUM_BITS;
    localparam int SQ_BITS   = 2 * ACCUM_BITS + 2;

    logic [ACCUM_BITS-1:0] mag_x;
    logic [ACCUM_BITS-1:0] mag_y;
    logic [ACCUM_BITS-1:0] dz_ext;
    logic [ACCUM_BITS:0]   mag_sum;
    logic [SQ_BITS-1:0]    sq_sum;
    logic [PROD_BITS-1:0]  sq_x;
    logic [PROD_BITS-1:0]  sq_y;
    logic                  reached;
    logic                  flat;
    logic                  steep;
    logic                  x_pos;
    logic                  y_pos;

    // Most negative value negates onto itself, which reads right as unsigned.
    assign mag_x  = x[ACCUM_BITS-1] ? $unsigned(-x) : $unsigned(x);
    assign mag_y  = y[ACCUM_BITS-1] ? $unsigned(-y) : $unsigned(y);
    assign dz_ext = {{(ACCUM_BITS-16){1'b0}}, deadzone};

    assign reached = (mag_x >= dz_ext) || (mag_y >= dz_ext);

    // a < tan(22.5 deg) * b  <=>  a < b and (a + b)^2 < 2 b^2, exact in integers
    assign mag_sum = {1'b0, mag_x} + {1'b0, mag_y};
    assign sq_sum  = SQ_BITS'(mag_sum) * SQ_BITS'(mag_sum);
    assign sq_x    = PROD_BITS'(mag_x) * PROD_BITS'(mag_x);
    assign sq_y    = PROD_BITS'(mag_y) * PROD_BITS'(mag_y);

    assign flat  = (mag_y < mag_x) && (sq_sum < {1'b0, sq_x, 1'b0});
    assign steep = (mag_x < mag_y) && (sq_sum < {1'b0, sq_y, 1'b0});

    assign x_pos = !x[ACCUM_BITS-1] && (x != '0);
    assign y_pos = !y[ACCUM_BITS-1] && (y != '0);

    always_comb
    begin
        if (!reached)
        begin
            direction = DIR_IDLE;
        end
        else if ((mag_x == '0) && (mag_y == '0))
        begin
            // zero deadzone with no motion lands on angle zero
            direction = DIR_RIGHT;
        end
        else if (flat)
        begin
            direction = x_pos ? DIR_RIGHT : DIR_LEFT;
        end
        else if (steep)
        begin
            direction = y_pos ? DIR_DOWN : DIR_UP;
        end
        else if (y_pos)
        begin
            direction = x_pos ? DIR_DOWN_RIGHT : DIR_DOWN_LEFT;
        end
        else
        begin
            direction = x_pos ? DIR_UP_RIGHT : DIR_UP_LEFT;
        end
    end

endmodule

// File: hdl/ewmq_core.sv
`timescale 1ns / 1ps

module ewmq_core
    import ewmq_pkg::*;
#(
    parameter int ACCUM_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    process,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    result_valid,
    output result_t result
);

    localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

    logic signed [ACCUM_BITS-1:0] accum_x_reg, accum_x_next;
    logic signed [ACCUM_BITS-1:0] accum_y_reg, accum_y_next;
    logic                         click_reg, click_next;
    dir_t                         stored_dir_reg, stored_dir_next;
    logic [31:0]                  next_due_reg, next_due_next;

    logic signed [ACCUM_BITS:0]   sum_x;
    logic signed [ACCUM_BITS:0]   sum_y;
    logic signed [ACCUM_BITS-1:0] sat_x;
    logic signed [ACCUM_BITS-1:0] sat_y;
    dir_t                         sector_dir;
    dir_t                         eval_dir;
    logic                         due;

    ewmq_sector #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_sector (
        .x         (accum_x_reg),
        .y         (accum_y_reg),
        .deadzone  (cfg.deadzone),
        .direction (sector_dir)
    );

    assign sum_x = {accum_x_reg[ACCUM_BITS-1], accum_x_reg} + (ACCUM_BITS+1)'(item.delta_x);
    assign sum_y = {accum_y_reg[ACCUM_BITS-1], accum_y_reg} + (ACCUM_BITS+1)'(item.delta_y);

    // clamp when the carry-out disagrees with the sign bit
    assign sat_x = (sum_x[ACCUM_BITS] != sum_x[ACCUM_BITS-1])
                 ? (sum_x[ACCUM_BITS] ? ACC_MIN : ACC_MAX) : sum_x[ACCUM_BITS-1:0];
    assign sat_y = (sum_y[ACCUM_BITS] != sum_y[ACCUM_BITS-1])
                 ? (sum_y[ACCUM_BITS] ? ACC_MIN : ACC_MAX) : sum_y[ACCUM_BITS-1:0];

    assign eval_dir = click_reg ? DIR_CLICK : sector_dir;
    assign due      = (item.now_ms >= next_due_reg);

    always_comb
    begin
        accum_x_next    = accum_x_reg;
        accum_y_next    = accum_y_reg;
        click_next      = click_reg;
        stored_dir_next = stored_dir_reg;
        next_due_next   = next_due_reg;
        result_valid    = process && (item.func == FUNC_STEP);
        result.fired     = 1'b0;
        result.changed   = 1'b0;
        result.direction = stored_dir_reg;

        if (process)
        begin
            case (item.func)
                FUNC_MOTION:
                begin
                    accum_x_next = sat_x;
                    accum_y_next = sat_y;
                end
                FUNC_CLICK:
                begin
                    click_next = 1'b1;
                end
                FUNC_STEP:
                begin
                    if (due)
                    begin
                        next_due_next    = item.now_ms + 32'(cfg.period_ms);
                        accum_x_next     = '0;
                        accum_y_next     = '0;
                        click_next       = 1'b0;
                        stored_dir_next  = eval_dir;
                        result.fired     = 1'b1;
                        result.changed   = (eval_dir != stored_dir_reg);
                        result.direction = eval_dir;
                    end
                end
                FUNC_RESET:
                begin
                    accum_x_next    = '0;
                    accum_y_next    = '0;
                    click_next      = 1'b0;
                    stored_dir_next = DIR_IDLE;
                    next_due_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            click_reg      <= 1'b0;
            stored_dir_reg <= DIR_IDLE;
            next_due_reg   <= '0;
        end
        else
        begin
            accum_x_reg    <= accum_x_next;
            accum_y_reg    <= accum_y_next;
            click_reg      <= click_next;
            stored_dir_reg <= stored_dir_next;
            next_due_reg   <= next_due_next;
        end
    end

endmodule

// File: hdl/eight_way_motion_quantizer.sv
`timescale 1ns / 1ps
// Eight-way motion quantizer. Takes one item per clock while the input is not held: an
// accepted beat sits in the input register until it advances, and is applied to the
// accumulator and timer state as it leaves, at the edge that loads a step item's
// result beat into the result register, from which the result is presented.
// Motion, click and reset items give no result. Only a step item waiting on a full,
// stalled result register holds the input; the sector test's squarers work
// combinationally on the accumulator registers, so they never hold the input.
// Configuration writes take effect at once and should only be issued while idle.
`include "eight_way_motion_quantizer_defines.svh"

module eight_way_motion_quantizer
    import ewmq_pkg::*;
#(
    parameter int ACCUM_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data
);

    logic [15:0] period_reg;
    logic [15:0] deadzone_reg;
    cfg_t        cfg;

    logic        stage_valid_reg, stage_valid_next;
    item_t       stage_item_reg, stage_item_next;
    logic        stage_is_step;
    logic        advance;

    logic        core_valid;
    result_t     core_result;

    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            deadzone_reg <= DEADZONE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PERIOD_MS: period_reg   <= (wr_data < PERIOD_MIN) ? PERIOD_MIN : wr_data;
                REG_DEADZONE:  deadzone_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    assign cfg.period_ms = period_reg;
    assign cfg.deadzone  = deadzone_reg;

    // only a step needs room in the result register
    assign stage_is_step = (stage_item_reg.func == FUNC_STEP);
    assign advance       = stage_valid_reg
                         && (!stage_is_step || !result_valid_reg || result_ready);
    assign item_ready    = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (item_valid && item_ready)
        begin
            stage_valid_next = 1'b1;
            stage_item_next  = item;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    ewmq_core #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .process      (advance),
        .item         (stage_item_reg),
        .cfg          (cfg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (core_valid)
        begin
            result_valid_next = 1'b1;
            result_next       = core_result;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `EWMQ_ASSERT_IMPL(a_changed_needs_fire, result_valid_reg && !result_reg.fired, !result_reg.changed, "changed reported without a fired evaluation")
    `EWMQ_ASSERT_IMPL(a_result_from_step, $rose(result_valid_reg), $past(advance && stage_is_step), "result beat not caused by a step item")
    `EWMQ_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !advance, stage_valid_reg && $stable(stage_item_reg), "stalled item lost from input register")

endmodule

// File: dv/motion_quantizer_checker.sv
`timescale 1ns / 1ps

module motion_quantizer_checker
    import ewmq_pkg::*;
#(
    parameter int ACCUM_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data,
    output int          mismatches,
    output int          reports_pending,
    output int          reports_checked,
    output int          evaluations
);

    localparam longint ACCUM_MAX = (longint'(1) << (ACCUM_BITS - 1)) - 1;
    localparam longint ACCUM_MIN = -ACCUM_MAX - 1;

    logic [15:0] period_ms      = PERIOD_RESET;
    logic [15:0] deadzone       = DEADZONE_RESET;
    longint      accum_x        = 0;
    longint      accum_y        = 0;
    logic        click_held     = 1'b0;
    dir_t        held_direction = DIR_IDLE;
    logic [31:0] next_due_ms    = '0;
    result_t     expected_reports[$];
    int          error_count    = 0;
    int          checked_count  = 0;
    int          fired_count    = 0;

    function automatic longint saturate(input longint value);
        if (value > ACCUM_MAX)
            return ACCUM_MAX;
        if (value < ACCUM_MIN)
            return ACCUM_MIN;
        return value;
    endfunction

    function automatic longint unsigned magnitude(input longint value);
        return (value < 0) ? -value : value;
    endfunction

    // a < tan(22.5 deg) * b, exact for integers
    function automatic bit below_tan22(input longint unsigned a, input longint unsigned b);
        if (a >= b)
            return 1'b0;
        return (a * a + 2 * a * b) < (b * b);
    endfunction

    function automatic dir_t sector_of(input longint x, input longint y);
        longint unsigned ax;
        longint unsigned ay;
        ax = magnitude(x);
        ay = magnitude(y);
        if (ax == 0 && ay == 0)
            return DIR_RIGHT;
        if (below_tan22(ay, ax))
            return (x > 0) ? DIR_RIGHT : DIR_LEFT;
        if (below_tan22(ax, ay))
            return (y > 0) ? DIR_DOWN : DIR_UP;
        if (y > 0)
            return (x > 0) ? DIR_DOWN_RIGHT : DIR_DOWN_LEFT;
        return (x > 0) ? DIR_UP_RIGHT : DIR_UP_LEFT;
    endfunction

    function automatic void clear_motion_state();
        accum_x        = 0;
        accum_y        = 0;
        click_held     = 1'b0;
        held_direction = DIR_IDLE;
        next_due_ms    = '0;
    endfunction

    // Apply one item; returns 1 when the item produces a report beat.
    function automatic bit quantize_item(input item_t it, output result_t report);
        dir_t dir;
        report = '0;
        case (it.func)
            FUNC_MOTION:
            begin
                accum_x = saturate(accum_x + longint'($signed(it.delta_x)));
                accum_y = saturate(accum_y + longint'($signed(it.delta_y)));
                return 1'b0;
            end
            FUNC_CLICK:
            begin
                click_held = 1'b1;
                return 1'b0;
            end
            FUNC_RESET:
            begin
                clear_motion_state();
                return 1'b0;
            end
            FUNC_STEP:
            begin
                if (it.now_ms < next_due_ms)
                begin
                    report.fired     = 1'b0;
                    report.changed   = 1'b0;
                    report.direction = held_direction;
                    return 1'b1;
                end
                next_due_ms = it.now_ms + 32'(period_ms);
                if (click_held)
                    dir = DIR_CLICK;
                else if (magnitude(accum_x) >= deadzone || magnitude(accum_y) >= deadzone)
                    dir = sector_of(accum_x, accum_y);
                else
                    dir = DIR_IDLE;
                report.fired     = 1'b1;
                report.changed   = (dir != held_direction);
                report.direction = dir;
                held_direction   = dir;
                click_held       = 1'b0;
                accum_x          = 0;
                accum_y          = 0;
                fired_count++;
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            period_ms = PERIOD_RESET;
            deadzone  = DEADZONE_RESET;
            clear_motion_state();
            expected_reports.delete();
            error_count   = 0;
            checked_count = 0;
            fired_count   = 0;
        end
        else
        begin
            // retire the output beat first: nothing accepted this edge can be due yet
            if (result_valid && result_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result beat with no step waiting: fired %0d changed %0d direction %0d",
                           result.fired, result.changed, result.direction);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    checked_count++;
                    if (result.fired !== want.fired)
                    begin
                        $error("fired: expected %0d, actual %0d", want.fired, result.fired);
                        error_count++;
                    end
                    if (result.changed !== want.changed)
                    begin
                        $error("changed: expected %0d, actual %0d", want.changed, result.changed);
                        error_count++;
                    end
                    if (result.direction !== want.direction)
                    begin
                        $error("direction: expected %0d, actual %0d",
                               want.direction, result.direction);
                        error_count++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                if (quantize_item(item, want))
                    expected_reports.push_back(want);
            end
            if (wr_en)
            begin
                if (wr_index == REG_PERIOD_MS)
                    period_ms = (wr_data < PERIOD_MIN) ? PERIOD_MIN : wr_data;
                else if (wr_index == REG_DEADZONE)
                    deadzone = wr_data;
            end
        end
        mismatches      <= error_count;
        reports_pending <= expected_reports.size();
        reports_checked <= checked_count;
        evaluations     <= fired_count;
    end

endmodule

// File: dv/eight_way_motion_quantizer_tb.sv
`timescale 1ns / 1ps

module eight_way_motion_quantizer_tb;
    import ewmq_pkg::*;

    localparam int ACCUM_BITS     = 24;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 95;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 4;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        wr_en        = 1'b0;
    logic        wr_index     = REG_PERIOD_MS;
    logic [15:0] wr_data      = '0;

    int          mismatches;
    int          reports_pending;
    int          reports_checked;
    int          evaluations;

    int          send_idle_pct   = 0;
    int          stall_pct       = 0;
    int          holdoff_req     = 0;
    int          holdoff_seen    = 0;
    int          holdoff_left    = 0;
    int          items_sent      = 0;
    int          steps_sent      = 0;
    int          watchdog_cycles = 0;
    int unsigned cur_period      = PERIOD_RESET;
    logic [31:0] clock_ms        = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    eight_way_motion_quantizer #(
        .ACCUM_BITS (ACCUM_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    motion_quantizer_checker #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .mismatches      (mismatches),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked),
        .evaluations     (evaluations)
    );

    // Output side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (holdoff_seen != holdoff_req)
        begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            result_ready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic item_t make_item(input func_t f, input logic signed [15:0] dx,
                                        input logic signed [15:0] dy, input logic [31:0] now);
        item_t it;
        it.func    = f;
        it.delta_x = dx;
        it.delta_y = dy;
        it.now_ms  = now;
        return it;
    endfunction

    // Mostly spread over magnitude scales, sometimes raw 16-bit noise.
    function automatic logic signed [15:0] motion_delta();
        int unsigned scale;
        logic [15:0] v;
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        scale = $urandom_range(15);
        v = 16'($urandom_range(0, (1 << scale) - 1));
        return $urandom_range(1) ? -$signed(v) : $signed(v);
    endfunction

    task automatic send_item(input item_t it);
        int gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (it.func == FUNC_STEP)
            steps_sent++;
    endtask

    // Hold the input until every report is back and the pipeline has settled.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] period, input logic [15:0] zone);
        wr_en    <= 1'b1;
        wr_index <= REG_PERIOD_MS;
        wr_data  <= period;
        @(posedge clk);
        wr_index <= REG_DEADZONE;
        wr_data  <= zone;
        @(posedge clk);
        wr_en    <= 1'b0;
        cur_period = (period < PERIOD_MIN) ? PERIOD_MIN : period;
    endtask

    task automatic step_at(input logic [31:0] now);
        send_item(make_item(FUNC_STEP, 16'($urandom), 16'($urandom), now));
    endtask

    task automatic play_sequence();
        int    kind;
        int    moves;
        item_t it;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            moves = $urandom_range(0, 6);
            repeat (moves)
                send_item(make_item(FUNC_MOTION, motion_delta(), motion_delta(), $urandom));
            if ($urandom_range(99) < 15)
                send_item(make_item(FUNC_CLICK, 16'($urandom), 16'($urandom), $urandom));
            if ($urandom_range(99) < 70)
                clock_ms += cur_period + $urandom_range(0, cur_period);
            else
                clock_ms += $urandom_range(0, cur_period - 1);
            step_at(clock_ms);
        end
        else
        begin
            it = make_item(func_t'($urandom_range(3)), 16'($urandom), 16'($urandom), $urandom);
            if (it.func == FUNC_STEP)
            begin
                // jump the clock, sometimes to just short of the 32-bit wrap
                if ($urandom_range(9) == 0)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, cur_period);
                else if ($urandom_range(1))
                    clock_ms = it.now_ms;
                it.now_ms = clock_ms;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        int phase;
        int start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: period 100, deadzone 32.
        step_at(32'd0);
        step_at(32'd99);
        send_item(make_item(FUNC_MOTION, 16'sh7FFF, 16'sh0000, 32'd0));
        step_at(32'd100);
        send_item(make_item(FUNC_MOTION, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF));
        step_at(32'd200);
        send_item(make_item(FUNC_MOTION, 16'sh0000, 16'sh7FFF, 32'd0));
        step_at(32'd300);
        send_item(make_item(FUNC_CLICK, 16'sh0000, 16'sh0000, 32'd0));
        send_item(make_item(FUNC_MOTION, 16'sd5, 16'sd5, 32'd0));
        step_at(32'd400);
        // just under the deadzone, then a shallow leftward vector
        send_item(make_item(FUNC_MOTION, 16'sd31, -16'sd31, 32'd0));
        step_at(32'd500);
        send_item(make_item(FUNC_MOTION, -16'sd32, 16'sd12, 32'd0));
        step_at(32'd600);
        send_item(make_item(FUNC_RESET, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF));
        step_at(32'd0);
        // next due time wraps past zero
        step_at(32'hFFFF_FFF0);
        step_at(32'h0000_0010);
        step_at(32'h0000_0054);
        drain();

        // zero deadzone with nothing accumulated reads as rightward
        configure(16'd5, 16'd0);
        step_at(32'hFFFF_FFFF);
        send_item(make_item(FUNC_MOTION, -16'sd1, 16'sd0, 32'd0));
        step_at(32'd20);

        for (phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                    configure(16'd15, 16'd0);
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct    <= 0;
                    configure(16'hFFFF, 16'hFFFF);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 83;
                    configure(16'($urandom_range(16, 400)), 16'($urandom_range(0, 3000)));
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct    <= 28;
                    configure(PERIOD_RESET, DEADZONE_RESET);
                end
            endcase

            if (phase == 0)
            begin
                // back up the output while steps keep coming
                holdoff_req <= holdoff_req + 1;
                repeat (30)
                begin
                    clock_ms += cur_period;
                    step_at(clock_ms);
                end
                // drive both accumulators into their limits
                repeat (260)
                    send_item(make_item(FUNC_MOTION, 16'sh7FFF, 16'sh8000, 32'd0));
                clock_ms += cur_period;
                step_at(clock_ms);
                drain();
            end

            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                play_sequence();
        end
        drain();

        $display("Summary: %0d items (%0d steps) over four flow-control phases and six settings",
                 items_sent, steps_sent);
        $display("Summary: %0d report beats compared, %0d of them fresh evaluations",
                 reports_checked, evaluations);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
